FILE: sv/mner_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mner_pkg
// Shared types, constants and small tables for the mesh edge neighbor
// recorder: table entry layout, controller states and control signal groups.
// ----------------------------------------------------------------------------
package mner_pkg;

    localparam int FACET_W    = 10;
    localparam int EDGE_W     = 3;
    localparam int SLOT_W     = 11;
    localparam int CODE_W     = 3;
    localparam int CNT_W      = 32;
    localparam int SEL_W      = 2;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [SLOT_W-1:0]     SLOT_EMPTY      = '1;
    localparam logic [EDGE_W-1:0]     EDGE_FWD_MAX    = 3'd2;
    localparam logic [CODE_W-1:0]     CODE_FLIP       = 3'd3;
    localparam logic [CNT_W-1:0]      EDGE_STEP       = 32'd2;
    localparam logic [SEL_W-1:0]      EMPTY_ONE_EDGE  = 2'd2;
    localparam logic [SEL_W-1:0]      EMPTY_TWO_EDGE  = 2'd1;
    localparam logic [APB_ADDR_W-1:0] ADDR_ERROR_HOLD = 3'd0;

    typedef struct packed {
        logic [2:0][SLOT_W-1:0] slot;
        logic [2:0][CODE_W-1:0] code;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam entry_t RESET_ENTRY = '{
        slot: {SLOT_EMPTY, SLOT_EMPTY, SLOT_EMPTY},
        code: '0
    };

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_REC_A,
        ST_REC_B
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic emit_read;
        logic wr_a;
        logic wr_b;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } status_t;

    // slot of an edge code: code mod 3
    function automatic logic [SEL_W-1:0] slot_of(input logic [EDGE_W-1:0] e);
        logic [SEL_W-1:0] s;
        case (e)
            3'd0, 3'd3, 3'd6: s = 2'd0;
            3'd1, 3'd4, 3'd7: s = 2'd1;
            default:          s = 2'd2;
        endcase
        return s;
    endfunction

    // opposite vertex of an edge code: (code + 2) mod 3
    function automatic logic [CODE_W-1:0] opp_of(input logic [EDGE_W-1:0] e);
        logic [CODE_W-1:0] c;
        case (e)
            3'd0, 3'd3, 3'd6: c = 3'd2;
            3'd1, 3'd4, 3'd7: c = 3'd0;
            default:          c = 3'd1;
        endcase
        return c;
    endfunction

    function automatic logic [SEL_W-1:0] empty_count(input entry_t e);
        logic [SEL_W-1:0] n;
        n = '0;
        for (int k = 0; k < 3; k++) begin
            if (e.slot[k] == SLOT_EMPTY) begin
                n = n + 2'd1;
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: sv/mner_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mner_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module mner_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: sv/mner_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mner_ctrl
// Controller: sequences the table clearing pass, request acceptance, the
// read-modify-write of both facet entries and the result strobe.
// ----------------------------------------------------------------------------
module mner_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              action,
    input  wire mner_pkg::status_t status,
    output mner_pkg::cmd_t         cmd,
    output logic                   busy
);

    import mner_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = action ? ST_READ : ST_REC_A;
                end
            end
            ST_READ:  state_next = ST_IDLE;
            ST_REC_A: state_next = ST_REC_B;
            ST_REC_B: state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_CLEAR: cmd.clear_wr = 1'b1;
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_READ:  cmd.emit_read = 1'b1;
            ST_REC_A: cmd.wr_a      = 1'b1;
            ST_REC_B: cmd.wr_b      = 1'b1;
            default:  busy          = 1'b1;
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/mner_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mner_datapath
// Datapath: neighbor table memory, request registers, entry update logic,
// statistics counters and result registers.
// ----------------------------------------------------------------------------
module mner_datapath #(
    parameter int FACET_COUNT = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire mner_pkg::cmd_t                cmd,
    output mner_pkg::status_t                  status,
    input  wire logic [mner_pkg::FACET_W-1:0]  facet_a,
    input  wire logic [mner_pkg::EDGE_W-1:0]   edge_a,
    input  wire logic [mner_pkg::FACET_W-1:0]  facet_b,
    input  wire logic [mner_pkg::EDGE_W-1:0]   edge_b,
    input  wire logic                          error_hold,
    output logic                               done,
    output logic [mner_pkg::CNT_W-1:0]         total_edges,
    output logic [mner_pkg::CNT_W-1:0]         one_edge_facets,
    output logic [mner_pkg::CNT_W-1:0]         two_edge_facets,
    output logic [mner_pkg::CNT_W-1:0]         three_edge_facets,
    output logic signed [mner_pkg::SLOT_W-1:0] slot_zero,
    output logic signed [mner_pkg::SLOT_W-1:0] slot_one,
    output logic signed [mner_pkg::SLOT_W-1:0] slot_two,
    output logic [mner_pkg::CODE_W-1:0]        code_zero,
    output logic [mner_pkg::CODE_W-1:0]        code_one,
    output logic [mner_pkg::CODE_W-1:0]        code_two
);

    import mner_pkg::*;

    localparam int  IDX_W     = $clog2(FACET_COUNT);
    localparam bit  POW2      = (FACET_COUNT & (FACET_COUNT - 1)) == 0;
    localparam bit  WIDE      = FACET_COUNT >= (1 << FACET_W);
    localparam logic [FACET_W-1:0] FACET_MASK = FACET_W'(FACET_COUNT - 1);
    localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(FACET_COUNT - 1);

    // facet index modulo the table depth
    function automatic logic [FACET_W-1:0] fold(input logic [FACET_W-1:0] v);
        logic [FACET_W-1:0] r;
        r = v;
        if (POW2)
        begin
            r = v & FACET_MASK;
        end
        else if (!WIDE)
        begin
            for (int k = FACET_W - 1; k >= 0; k--)
            begin
                if ((FACET_COUNT << k) < (1 << FACET_W))
                begin
                    if (r >= FACET_W'(FACET_COUNT << k))
                    begin
                        r = r - FACET_W'(FACET_COUNT << k);
                    end
                end
            end
        end
        return r;
    endfunction

    logic [IDX_W-1:0]   clr_cnt_reg;
    logic [FACET_W-1:0] fa_reg;
    logic [FACET_W-1:0] fb_reg;
    logic [EDGE_W-1:0]  ea_reg;
    logic [EDGE_W-1:0]  eb_reg;
    entry_t             entry_a_reg;

    logic [CNT_W-1:0] edges_reg, edges_next;
    logic [CNT_W-1:0] one_reg, one_next;
    logic [CNT_W-1:0] two_reg, two_next;
    logic [CNT_W-1:0] three_reg, three_next;

    logic                     done_reg;
    logic [CNT_W-1:0]         res_edges_reg, res_one_reg, res_two_reg, res_three_reg;
    logic signed [SLOT_W-1:0] res_slot0_reg, res_slot1_reg, res_slot2_reg;
    logic [CODE_W-1:0]        res_code0_reg, res_code1_reg, res_code2_reg;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;

    logic             flip;
    logic [CODE_W-1:0] code_a, code_b;
    logic [SEL_W-1:0] sa, sb;
    logic             same;
    entry_t           new_a, base_b, new_b, final_a;
    logic [SEL_W-1:0] empty_a, empty_b;
    logic [SEL_W-1:0] one_inc, two_inc, three_inc;
    logic             commit;

    assign rd_entry = entry_t'(ram_rdata);

    mner_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FACET_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        flip   = (ea_reg > EDGE_FWD_MAX) == (eb_reg > EDGE_FWD_MAX);
        code_a = opp_of(eb_reg) + (flip ? CODE_FLIP : '0);
        code_b = opp_of(ea_reg) + (flip ? CODE_FLIP : '0);
        sa     = slot_of(ea_reg);
        sb     = slot_of(eb_reg);
        same   = fa_reg == fb_reg;

        new_a              = rd_entry;
        new_a.slot[sa]     = {1'b0, fb_reg};
        new_a.code[sa]     = code_a;

        // same facet: the table still holds the old entry, take the update
        base_b             = same ? entry_a_reg : rd_entry;
        new_b              = base_b;
        new_b.slot[sb]     = {1'b0, fa_reg};
        new_b.code[sb]     = code_b;
        final_a            = same ? new_b : entry_a_reg;

        empty_a = empty_count(final_a);
        empty_b = empty_count(new_b);
    end

    always_comb
    begin
        one_inc   = '0;
        two_inc   = '0;
        three_inc = '0;
        case (empty_a)
            EMPTY_ONE_EDGE: one_inc   = one_inc + 2'd1;
            EMPTY_TWO_EDGE: two_inc   = two_inc + 2'd1;
            default:        three_inc = three_inc + 2'd1;
        endcase
        case (empty_b)
            EMPTY_ONE_EDGE: one_inc   = one_inc + 2'd1;
            EMPTY_TWO_EDGE: two_inc   = two_inc + 2'd1;
            default:        three_inc = three_inc + 2'd1;
        endcase
    end

    assign commit = cmd.wr_b & ~error_hold;

    always_comb
    begin
        edges_next = edges_reg;
        one_next   = one_reg;
        two_next   = two_reg;
        three_next = three_reg;
        if (commit)
        begin
            edges_next = edges_reg + EDGE_STEP;
            one_next   = one_reg + CNT_W'(one_inc);
            two_next   = two_reg + CNT_W'(two_inc);
            three_next = three_reg + CNT_W'(three_inc);
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = RESET_ENTRY;
        if (cmd.clear_wr)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.wr_a)
        begin
            ram_we    = ~error_hold;
            ram_waddr = IDX_W'(fa_reg);
            ram_wdata = new_a;
        end
        else if (cmd.wr_b)
        begin
            ram_we    = ~error_hold;
            ram_waddr = IDX_W'(fb_reg);
            ram_wdata = new_b;
        end
    end

    assign ram_re    = cmd.load | cmd.wr_a;
    assign ram_raddr = cmd.load ? IDX_W'(fold(facet_a)) : IDX_W'(fb_reg);

    assign status.clear_last = clr_cnt_reg == LAST_IDX;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            edges_reg   <= '0;
            one_reg     <= '0;
            two_reg     <= '0;
            three_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            edges_reg <= edges_next;
            one_reg   <= one_next;
            two_reg   <= two_next;
            three_reg <= three_next;
            done_reg  <= cmd.emit_read | cmd.wr_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fa_reg <= fold(facet_a);
            fb_reg <= fold(facet_b);
            ea_reg <= edge_a;
            eb_reg <= edge_b;
        end
        if (cmd.wr_a)
        begin
            entry_a_reg <= new_a;
        end
        if (cmd.emit_read | cmd.wr_b)
        begin
            res_edges_reg <= edges_next;
            res_one_reg   <= one_next;
            res_two_reg   <= two_next;
            res_three_reg <= three_next;
            if (cmd.emit_read)
            begin
                res_slot0_reg <= $signed(rd_entry.slot[0]);
                res_slot1_reg <= $signed(rd_entry.slot[1]);
                res_slot2_reg <= $signed(rd_entry.slot[2]);
                res_code0_reg <= rd_entry.code[0];
                res_code1_reg <= rd_entry.code[1];
                res_code2_reg <= rd_entry.code[2];
            end
            else
            begin
                res_slot0_reg <= '0;
                res_slot1_reg <= '0;
                res_slot2_reg <= '0;
                res_code0_reg <= '0;
                res_code1_reg <= '0;
                res_code2_reg <= '0;
            end
        end
    end

    assign done              = done_reg;
    assign total_edges       = res_edges_reg;
    assign one_edge_facets   = res_one_reg;
    assign two_edge_facets   = res_two_reg;
    assign three_edge_facets = res_three_reg;
    assign slot_zero         = res_slot0_reg;
    assign slot_one          = res_slot1_reg;
    assign slot_two          = res_slot2_reg;
    assign code_zero         = res_code0_reg;
    assign code_one          = res_code1_reg;
    assign code_two          = res_code2_reg;

endmodule
`default_nettype wire

FILE: sv/mesh_edge_neighbor_recorder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_edge_neighbor_recorder_unit
// Per-facet neighbor table with three slots and opposite-vertex codes per
// facet, plus edge statistics counters, with an APB error hold register.
// ----------------------------------------------------------------------------
// After reset the unit clears its neighbor table, one entry per cycle, with
// busy high. A request is taken when start is high and busy is low. A read
// request reads the entry in the read state and registers its result there,
// and the unit then returns to idle for the next request. A record request
// reads the first facet entry, then writes both entries through the single
// table write port, so its result is registered in the second write state.
// Each result is marked by done, high for exactly one cycle; the receiver
// cannot stall it, and it must capture the result in that cycle.
// ----------------------------------------------------------------------------
module mesh_edge_neighbor_recorder_unit #(
    parameter int FACET_COUNT = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             action,
    input  wire logic [mner_pkg::FACET_W-1:0]     facet_a,
    input  wire logic [mner_pkg::EDGE_W-1:0]      edge_a,
    input  wire logic [mner_pkg::FACET_W-1:0]     facet_b,
    input  wire logic [mner_pkg::EDGE_W-1:0]      edge_b,
    output logic                                  done,
    output logic [mner_pkg::CNT_W-1:0]            total_edges,
    output logic [mner_pkg::CNT_W-1:0]            one_edge_facets,
    output logic [mner_pkg::CNT_W-1:0]            two_edge_facets,
    output logic [mner_pkg::CNT_W-1:0]            three_edge_facets,
    output logic signed [mner_pkg::SLOT_W-1:0]    slot_zero,
    output logic signed [mner_pkg::SLOT_W-1:0]    slot_one,
    output logic signed [mner_pkg::SLOT_W-1:0]    slot_two,
    output logic [mner_pkg::CODE_W-1:0]           code_zero,
    output logic [mner_pkg::CODE_W-1:0]           code_one,
    output logic [mner_pkg::CODE_W-1:0]           code_two,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mner_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [mner_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mner_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);

    import mner_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    error_hold_reg;
    logic    hold_sel;

    assign pready   = 1'b1;
    assign hold_sel = paddr == ADDR_ERROR_HOLD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_hold_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && hold_sel)
        begin
            error_hold_reg <= pwdata[0];
        end
    end

    assign prdata = hold_sel ? {{(APB_DATA_W-1){1'b0}}, error_hold_reg} : '0;

    mner_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mner_datapath #(
        .FACET_COUNT (FACET_COUNT)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .facet_a           (facet_a),
        .edge_a            (edge_a),
        .facet_b           (facet_b),
        .edge_b            (edge_b),
        .error_hold        (error_hold_reg),
        .done              (done),
        .total_edges       (total_edges),
        .one_edge_facets   (one_edge_facets),
        .two_edge_facets   (two_edge_facets),
        .three_edge_facets (three_edge_facets),
        .slot_zero         (slot_zero),
        .slot_one          (slot_one),
        .slot_two          (slot_two),
        .code_zero         (code_zero),
        .code_one          (code_one),
        .code_two          (code_two)
    );

endmodule
`default_nettype wire
